[hw/rtl/sixteen_bit_risc_cpu_step_assert.svh]
// Assertion macros for the processor step block
`ifndef SIXTEEN_BIT_RISC_CPU_STEP_ASSERT_SVH
`define SIXTEEN_BIT_RISC_CPU_STEP_ASSERT_SVH

// antecedent holds -> consequent holds in the same cycle
`define SRCS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent holds -> consequent holds in the next cycle
`define SRCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hw/rtl/srcs_pkg.sv]
// Shared types and constants for the processor step block
`timescale 1ns / 1ps
package srcs_pkg;

    localparam logic [15:0] PC_RESET   = 16'h8200;
    localparam logic [15:0] USER_DATA  = 16'h2000;
    localparam logic [15:0] OS_CODE    = 16'h8000;
    localparam logic [15:0] OS_DATA    = 16'hA000;
    localparam logic [15:0] BYTE_MASK  = 16'h00FF;
    localparam int unsigned MEM_DEPTH  = 32768 * 2;
    localparam int unsigned MEM_AW     = $clog2(MEM_DEPTH);

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    localparam logic [3:0] OP_BR     = 4'h0;
    localparam logic [3:0] OP_ARITH  = 4'h1;
    localparam logic [3:0] OP_CMP    = 4'h2;
    localparam logic [3:0] OP_JSR    = 4'h4;
    localparam logic [3:0] OP_LOGIC  = 4'h5;
    localparam logic [3:0] OP_LDR    = 4'h6;
    localparam logic [3:0] OP_STR    = 4'h7;
    localparam logic [3:0] OP_RTI    = 4'h8;
    localparam logic [3:0] OP_CONST  = 4'h9;
    localparam logic [3:0] OP_SHIFT  = 4'hA;
    localparam logic [3:0] OP_JMP    = 4'hC;
    localparam logic [3:0] OP_HICON  = 4'hD;
    localparam logic [3:0] OP_TRAP   = 4'hF;

    localparam logic [2:0] NZP_N = 3'd4;
    localparam logic [2:0] NZP_Z = 3'd2;
    localparam logic [2:0] NZP_P = 3'd1;

    typedef struct packed {
        logic        kind;
        logic [15:0] load_address;
        logic [15:0] load_data;
    } t_in_item;

    typedef struct packed {
        logic        fault;
        logic [15:0] pc;
        logic [15:0] instruction;
        logic        reg_write;
        logic [2:0]  reg_number;
        logic [15:0] reg_value;
        logic        nzp_write;
        logic [2:0]  nzp_value;
        logic        data_access;
        logic        data_write;
        logic [15:0] data_address;
        logic [15:0] data_value;
    } t_out_item;

    typedef struct packed {
        logic clearing;
        logic halted;
    } t_core_status;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_DECODE, ST_EXEC, ST_DIV, ST_LOADW, ST_COMMIT
    } t_core_state;

endpackage

[hw/rtl/sixteen_bit_risc_cpu_step.sv]
// Top level of the 16-bit processor step block
//  channel | direction | handshake            | payload
//  in      | input     | i_in_valid/o_in_stall | i_in_data  (t_in_item)
//  out     | output    | o_out_valid/i_out_stall | o_out_data (t_out_item)
// After reset the memory is swept to zero, one word a cycle, while the input stalls.
// A beat enters the queue at its accepting edge; the sequencer takes it once idle.
// Load beat: one write to memory. Step: fetch, decode, execute into the output
// register; LDR adds load wait and commit, DIV and MOD the one-bit-a-cycle divider.
// A two-entry queue parts the input from the sequencer; the output register holds
// a stalled record while the next beat is taken in.
`timescale 1ns / 1ps
`include "sixteen_bit_risc_cpu_step_assert.svh"
module sixteen_bit_risc_cpu_step import srcs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);
    t_core_status status;
    logic         q_valid, q_pop;
    t_in_item     q_data;

    srcs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_status   (status),
        .o_q_valid  (q_valid),
        .o_q_data   (q_data),
        .i_q_pop    (q_pop)
    );

    srcs_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_data),
        .o_q_pop     (q_pop),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    `SRCS_ASSERT_IMPL(a_clear_stalls, i_clk, i_rst_n, status.clearing, o_in_stall)
    `SRCS_ASSERT_IMPL(a_fault_clean, i_clk, i_rst_n, o_out_valid && o_out_data.fault, !o_out_data.reg_write && !o_out_data.data_access && !o_out_data.nzp_write)
    `SRCS_ASSERT_NEXT(a_halt_silent, i_clk, i_rst_n, status.halted, !$rose(o_out_valid))
endmodule

[hw/rtl/srcs_front.sv]
// Front end: accepts input beats into a two-entry queue
`timescale 1ns / 1ps
module srcs_front import srcs_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_stall,
    input  t_in_item     i_in_data,
    input  t_core_status i_status,
    output logic         o_q_valid,
    output t_in_item     o_q_data,
    input  logic         i_q_pop
);
    t_in_item   r_ent [0:1];
    logic       r_rd, r_wr;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_in_stall = (r_cnt == 2'd2) || i_status.clearing;
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign pop        = i_q_pop && o_q_valid;
    assign o_q_data   = r_ent[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ent[r_wr] <= i_in_data;
        end
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= !r_wr;
            end
            if (pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

[hw/rtl/srcs_div.sv]
// Iterative 16-bit unsigned divider, one quotient bit a cycle
`timescale 1ns / 1ps
module srcs_div import srcs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_done,
    output logic [15:0] o_quo,
    output logic [15:0] o_rem
);
    logic [15:0] r_rem, r_quo, r_dsr;
    logic [3:0]  r_cnt;
    logic        r_busy, r_done, r_zero;
    logic [16:0] trial;

    assign trial  = {r_rem, r_quo[15]} - {1'b0, r_dsr};
    assign o_done = r_done;
    assign o_quo  = r_zero ? 16'd0 : r_quo;
    assign o_rem  = r_zero ? 16'd0 : r_rem;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= 16'd0;
            r_quo  <= i_dividend;
            r_dsr  <= i_divisor;
            r_zero <= (i_divisor == 16'd0);
        end else if (r_busy) begin
            if (!trial[16]) begin
                r_rem <= trial[15:0];
                r_quo <= {r_quo[14:0], 1'b1};
            end else begin
                r_rem <= {r_rem[14:0], r_quo[15]};
                r_quo <= {r_quo[14:0], 1'b0};
            end
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 4'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

[hw/rtl/srcs_core.sv]
// Back end: memory, register file, sequencer and trace output register
`timescale 1ns / 1ps
module srcs_core import srcs_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_q_valid,
    input  t_in_item     i_q_data,
    output logic         o_q_pop,
    output t_core_status o_status,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output t_out_item    o_out_data
);
    logic [15:0] r_mem [0:MEM_DEPTH-1];
    logic [15:0] r_mem_q;
    logic [15:0] r_regs [0:7];
    logic [15:0] r_pc, r_ir, r_a, r_b, r_x, r_res;
    logic        r_priv, r_halted;
    logic [2:0]  r_flags;
    logic [MEM_AW-1:0] r_clr;
    t_core_state r_state, n_state;
    logic        r_out_valid;
    t_out_item   r_out;

    logic        mem_we, mem_re, div_start, commit, latch_ir, latch_res;
    logic [MEM_AW-1:0] mem_wa, mem_ra;
    logic [15:0] mem_wd;
    logic        out_free;
    logic        div_done;
    logic [15:0] div_quo, div_rem;

    // decode / execute
    logic [3:0]  op;
    logic [2:0]  rd;
    logic [15:0] s5, s6, s7, s9, s11, nxt, alu, res, addr;
    logic        fetch_ok, data_ok, fault, rw, nw, da, dw, need_div, div_is_mod, ld_go;
    logic        priv_n;
    logic [2:0]  rn, nv, cmp_nv;
    logic [15:0] cmp_lhs, cmp_rhs;
    logic        cmp_signed;
    t_out_item   rec;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_status    = '{clearing: (r_state == ST_CLEAR), halted: r_halted};

    srcs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_a),
        .i_divisor  (r_b),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    always_comb begin
        op   = r_ir[15:12];
        rd   = r_ir[11:9];
        s5   = {{11{r_ir[4]}}, r_ir[4:0]};
        s6   = {{10{r_ir[5]}}, r_ir[5:0]};
        s7   = {{9{r_ir[6]}}, r_ir[6:0]};
        s9   = {{7{r_ir[8]}}, r_ir[8:0]};
        s11  = {{5{r_ir[10]}}, r_ir[10:0]};
        addr = r_a + s6;
        fetch_ok = (r_pc < USER_DATA) || (r_pc >= OS_CODE && r_pc < OS_DATA && r_priv);
        data_ok  = (addr >= USER_DATA && addr < OS_CODE) || (addr >= OS_DATA && r_priv);
        nxt    = r_pc + 16'd1;
        alu    = 16'd0;
        fault  = 1'b0;
        rw     = 1'b0;
        rn     = rd;
        nw     = 1'b0;
        da     = 1'b0;
        dw     = 1'b0;
        need_div   = 1'b0;
        div_is_mod = 1'b0;
        priv_n = r_priv;
        cmp_signed = 1'b0;
        cmp_lhs = r_x;
        cmp_rhs = r_b;
        unique case (r_ir[8:7])
            2'd0: begin cmp_signed = 1'b1; cmp_rhs = r_b; end
            2'd1: begin cmp_signed = 1'b0; cmp_rhs = r_b; end
            2'd2: begin cmp_signed = 1'b1; cmp_rhs = s7; end
            default: begin cmp_signed = 1'b0; cmp_rhs = {9'd0, r_ir[6:0]}; end
        endcase
        if (cmp_signed ? ($signed(cmp_lhs) < $signed(cmp_rhs)) : (cmp_lhs < cmp_rhs)) begin
            cmp_nv = NZP_N;
        end else if (cmp_lhs == cmp_rhs) begin
            cmp_nv = NZP_Z;
        end else begin
            cmp_nv = NZP_P;
        end
        if (!fetch_ok) begin
            fault = 1'b1;
        end else begin
            unique case (op)
                OP_BR: begin
                    if (rd == 3'd7 || (rd & r_flags) != 3'd0) begin
                        nxt = r_pc + 16'd1 + s9;
                    end
                end
                OP_ARITH: begin
                    rw = 1'b1;
                    priority case (1'b1)
                        r_ir[5]:                alu = r_a + s5;
                        r_ir[4:3] == 2'd0:      alu = r_a + r_b;
                        r_ir[4:3] == 2'd1:      alu = r_a * r_b;
                        r_ir[4:3] == 2'd2:      alu = r_a - r_b;
                        default:                need_div = 1'b1;
                    endcase
                end
                OP_CMP: begin
                    nw = 1'b1;
                end
                OP_JSR: begin
                    rw  = 1'b1;
                    rn  = 3'd7;
                    alu = nxt;
                    nxt = r_ir[11] ? {r_pc[15] | s11[11], s11[10:0], 4'd0} : r_a;
                end
                OP_LOGIC: begin
                    rw = 1'b1;
                    priority case (1'b1)
                        r_ir[5]:                alu = r_a & s5;
                        r_ir[4:3] == 2'd0:      alu = r_a & r_b;
                        r_ir[4:3] == 2'd1:      alu = ~r_a;
                        r_ir[4:3] == 2'd2:      alu = r_a | r_b;
                        default:                alu = r_a ^ r_b;
                    endcase
                end
                OP_LDR: begin
                    if (!data_ok) begin
                        fault = 1'b1;
                    end else begin
                        da = 1'b1;
                        rw = 1'b1;
                    end
                end
                OP_STR: begin
                    if (!data_ok) begin
                        fault = 1'b1;
                    end else begin
                        da = 1'b1;
                        dw = 1'b1;
                    end
                end
                OP_RTI: begin
                    nxt    = r_regs[7];
                    priv_n = 1'b0;
                end
                OP_CONST: begin
                    rw  = 1'b1;
                    alu = s9;
                end
                OP_SHIFT: begin
                    rw = 1'b1;
                    unique case (r_ir[5:4])
                        2'd0:    alu = r_a << r_ir[3:0];
                        2'd1:    alu = $unsigned($signed(r_a) >>> r_ir[3:0]);
                        2'd2:    alu = r_a >> r_ir[3:0];
                        default: begin need_div = 1'b1; div_is_mod = 1'b1; end
                    endcase
                end
                OP_JMP: begin
                    nxt = r_ir[11] ? (r_pc + 16'd1 + s11) : r_a;
                end
                OP_HICON: begin
                    if (!r_ir[8]) begin
                        fault = 1'b1;
                    end else begin
                        rw  = 1'b1;
                        alu = {r_ir[7:0], r_x[7:0]};
                    end
                end
                OP_TRAP: begin
                    rw     = 1'b1;
                    rn     = 3'd7;
                    alu    = nxt;
                    nxt    = OS_CODE | (r_ir & BYTE_MASK);
                    priv_n = 1'b1;
                end
                default: fault = 1'b1;
            endcase
        end
        ld_go = (op == OP_LDR) && !fault;
        res   = (r_state == ST_COMMIT) ? r_res : alu;
        if (res[15]) begin
            nv = NZP_N;
        end else if (res == 16'd0) begin
            nv = NZP_Z;
        end else begin
            nv = NZP_P;
        end
        rec             = '0;
        rec.pc          = r_pc;
        rec.instruction = r_ir;
        if (fault) begin
            rec.fault = 1'b1;
        end else begin
            if (rw) begin
                rec.reg_write  = 1'b1;
                rec.reg_number = rn;
                rec.reg_value  = res;
                rec.nzp_write  = 1'b1;
                rec.nzp_value  = nv;
            end else if (nw) begin
                rec.nzp_write  = 1'b1;
                rec.nzp_value  = cmp_nv;
            end
            if (da) begin
                rec.data_access  = 1'b1;
                rec.data_write   = dw;
                rec.data_address = addr;
                rec.data_value   = dw ? r_x : res;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:  if (r_clr == MEM_AW'(MEM_DEPTH - 1)) n_state = ST_IDLE;
            ST_IDLE:   if (i_q_valid && i_q_data.kind == KIND_STEP && !r_halted)
                           n_state = ST_DECODE;
            ST_DECODE: n_state = ST_EXEC;
            ST_EXEC: begin
                if (need_div) begin
                    n_state = ST_DIV;
                end else if (ld_go) begin
                    n_state = ST_LOADW;
                end else if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_DIV:    if (div_done) n_state = ST_COMMIT;
            ST_LOADW:  n_state = ST_COMMIT;
            ST_COMMIT: if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_q_pop   = 1'b0;
        mem_we    = 1'b0;
        mem_wa    = r_clr;
        mem_wd    = 16'd0;
        mem_re    = 1'b0;
        mem_ra    = r_pc;
        div_start = 1'b0;
        commit    = 1'b0;
        latch_ir  = 1'b0;
        latch_res = 1'b0;
        unique case (r_state)
            ST_CLEAR: mem_we = 1'b1;
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q_data.kind == KIND_LOAD) begin
                        mem_we = 1'b1;
                        mem_wa = i_q_data.load_address;
                        mem_wd = i_q_data.load_data;
                    end else if (!r_halted) begin
                        mem_re = 1'b1;
                    end
                end
            end
            ST_DECODE: latch_ir = 1'b1;
            ST_EXEC: begin
                if (need_div) begin
                    div_start = 1'b1;
                end else if (ld_go) begin
                    mem_re = 1'b1;
                    mem_ra = addr;
                end else begin
                    commit = out_free;
                end
            end
            ST_DIV:    latch_res = div_done;
            ST_LOADW:  latch_res = 1'b1;
            ST_COMMIT: commit = out_free;
            default: ;
        endcase
        if (commit && dw) begin
            mem_we = 1'b1;
            mem_wa = addr;
            mem_wd = r_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_mem_q <= r_mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (latch_ir) begin
            r_ir <= r_mem_q;
            r_a  <= r_regs[r_mem_q[8:6]];
            r_b  <= r_regs[r_mem_q[2:0]];
            r_x  <= r_regs[r_mem_q[11:9]];
        end
        if (latch_res) begin
            if (r_state == ST_LOADW) begin
                r_res <= r_mem_q;
            end else begin
                r_res <= div_is_mod ? div_rem : div_quo;
            end
        end
        if (commit) begin
            r_out <= rec;
        end
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_pc        <= PC_RESET;
            r_priv      <= 1'b1;
            r_flags     <= 3'd0;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 8; k++) begin
                r_regs[k] <= 16'd0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + MEM_AW'(1);
            end
            if (commit) begin
                r_out_valid <= 1'b1;
                if (fault) begin
                    r_halted <= 1'b1;
                end else begin
                    r_pc   <= nxt;
                    r_priv <= priv_n;
                    if (rw) begin
                        r_regs[rn] <= res;
                        r_flags    <= nv;
                    end else if (nw) begin
                        r_flags <= cmp_nv;
                    end
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end
endmodule

[tb/sv/sixteen_bit_risc_cpu_step_checker.sv]
// Checker for the processor step block: predicts trace records and compares them
`timescale 1ns / 1ps
module sixteen_bit_risc_cpu_step_checker import srcs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  t_in_item         i_in_data,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  t_out_item        i_out_data,
    output logic [15:0]      o_pc,
    output logic             o_priv,
    output logic [7:0][15:0] o_regs,
    output int               o_pending,
    output int               o_failures
);

    logic [15:0] mem [MEM_DEPTH];
    logic [7:0][15:0] rf;
    logic [15:0] pc;
    logic        priv;
    logic [2:0]  flags;
    logic        halted;
    t_out_item   trace_q[$];
    int          failures;

    assign o_pc       = pc;
    assign o_priv     = priv;
    assign o_regs     = rf;
    assign o_pending  = trace_q.size();
    assign o_failures = failures;

    initial begin
        foreach (mem[k]) mem[k] = '0;
        failures = 0;
    end

    function automatic logic fetch_ok(input logic [15:0] a);
        return a < USER_DATA || (a >= OS_CODE && a < OS_DATA && priv);
    endfunction

    function automatic logic data_ok(input logic [15:0] a);
        return (a >= USER_DATA && a < OS_CODE) || (a >= OS_DATA && priv);
    endfunction

    function automatic logic [2:0] order3(input logic signed [16:0] p, input logic signed [16:0] q);
        if (p < q) return NZP_N;
        if (p == q) return NZP_Z;
        return NZP_P;
    endfunction

    function automatic logic [2:0] sign3(input logic [15:0] x);
        if (x[15]) return NZP_N;
        if (x == 0) return NZP_Z;
        return NZP_P;
    endfunction

    task automatic execute_step();
        t_out_item   t;
        logic [15:0] ir, nxt, a, b, x, r, addr, dval;
        logic [15:0] sx5, sx6, sx7, sx9, sx11;
        logic        flt, rw, nw, da, dw;
        logic [2:0]  rn, nv;
        ir = mem[pc];
        nxt = pc + 16'd1;
        a = rf[ir[8:6]];
        b = rf[ir[2:0]];
        x = rf[ir[11:9]];
        sx5 = {{11{ir[4]}}, ir[4:0]};
        sx6 = {{10{ir[5]}}, ir[5:0]};
        sx7 = {{9{ir[6]}}, ir[6:0]};
        sx9 = {{7{ir[8]}}, ir[8:0]};
        sx11 = {{5{ir[10]}}, ir[10:0]};
        r = '0; addr = '0; dval = '0; rn = '0; nv = '0;
        flt = 0; rw = 0; nw = 0; da = 0; dw = 0;
        if (!fetch_ok(pc)) begin
            flt = 1;
        end else begin
            case (ir[15:12])
                OP_BR: if (ir[11:9] == 3'd7 || (ir[11:9] & flags) != 0) nxt = pc + 16'd1 + sx9;
                OP_ARITH: begin
                    if (ir[5]) r = a + sx5;
                    else case (ir[4:3])
                        2'd0: r = a + b;
                        2'd1: r = a * b;
                        2'd2: r = a - b;
                        default: r = (b != 0) ? a / b : 16'd0;
                    endcase
                    rw = 1; rn = ir[11:9];
                end
                OP_CMP: begin
                    case (ir[8:7])
                        2'd0: nv = order3({x[15], x}, {b[15], b});
                        2'd1: nv = order3({1'b0, x}, {1'b0, b});
                        2'd2: nv = order3({x[15], x}, {sx7[15], sx7});
                        default: nv = order3({1'b0, x}, {10'd0, ir[6:0]});
                    endcase
                    nw = 1; flags = nv;
                end
                OP_JSR: begin
                    r = nxt;
                    nxt = ir[11] ? ((pc & 16'h8000) | (sx11 << 4)) : a;
                    rw = 1; rn = 3'd7;
                end
                OP_LOGIC: begin
                    if (ir[5]) r = a & sx5;
                    else case (ir[4:3])
                        2'd0: r = a & b;
                        2'd1: r = ~a;
                        2'd2: r = a | b;
                        default: r = a ^ b;
                    endcase
                    rw = 1; rn = ir[11:9];
                end
                OP_LDR, OP_STR: begin
                    addr = a + sx6;
                    if (!data_ok(addr)) begin
                        flt = 1;
                    end else begin
                        da = 1;
                        if (ir[15:12] == OP_LDR) begin
                            dval = mem[addr]; r = dval; rw = 1; rn = ir[11:9];
                        end else begin
                            dw = 1; dval = x; mem[addr] = dval;
                        end
                    end
                end
                OP_RTI: begin
                    nxt = rf[7]; priv = 0;
                end
                OP_CONST: begin
                    r = sx9; rw = 1; rn = ir[11:9];
                end
                OP_SHIFT: begin
                    case (ir[5:4])
                        2'd0: r = a << ir[3:0];
                        2'd1: r = $unsigned($signed(a) >>> ir[3:0]);
                        2'd2: r = a >> ir[3:0];
                        default: r = (b != 0) ? a % b : 16'd0;
                    endcase
                    rw = 1; rn = ir[11:9];
                end
                OP_JMP: nxt = ir[11] ? pc + 16'd1 + sx11 : a;
                OP_HICON: begin
                    if (!ir[8]) flt = 1;
                    else begin
                        r = {ir[7:0], x[7:0]}; rw = 1; rn = ir[11:9];
                    end
                end
                OP_TRAP: begin
                    r = nxt; nxt = OS_CODE | (ir & BYTE_MASK); priv = 1;
                    rw = 1; rn = 3'd7;
                end
                default: flt = 1;
            endcase
        end
        t = '0;
        t.pc = pc;
        t.instruction = ir;
        if (flt) begin
            halted = 1;
            t.fault = 1;
        end else begin
            if (rw) begin
                rf[rn] = r;
                nv = sign3(r);
                nw = 1;
                flags = nv;
                t.reg_write = 1; t.reg_number = rn; t.reg_value = r;
            end
            if (nw) begin
                t.nzp_write = 1; t.nzp_value = nv;
            end
            if (da) begin
                t.data_access = 1; t.data_write = dw; t.data_address = addr; t.data_value = dval;
            end
            pc = nxt;
        end
        trace_q.push_back(t);
    endtask

    task automatic check_field(input string name, input logic [15:0] e, input logic [15:0] g);
        if (e !== g) begin
            $error("%s: expected %h, got %h", name, e, g);
            failures++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item e, g;
        if (!i_rst_n) begin
            rf = '0;
            pc = PC_RESET;
            priv = 1;
            flags = '0;
            halted = 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                if (i_in_data.kind == KIND_LOAD) mem[i_in_data.load_address] = i_in_data.load_data;
                else if (!halted) execute_step();
            end
            if (i_out_valid && !i_out_stall) begin
                g = i_out_data;
                if (trace_q.size() == 0) begin
                    $error("unexpected trace record at pc %h", g.pc);
                    failures++;
                end else begin
                    e = trace_q.pop_front();
                    check_field("fault", e.fault, g.fault);
                    check_field("pc", e.pc, g.pc);
                    check_field("instruction", e.instruction, g.instruction);
                    check_field("reg_write", e.reg_write, g.reg_write);
                    check_field("reg_number", e.reg_number, g.reg_number);
                    check_field("reg_value", e.reg_value, g.reg_value);
                    check_field("nzp_write", e.nzp_write, g.nzp_write);
                    check_field("nzp_value", e.nzp_value, g.nzp_value);
                    check_field("data_access", e.data_access, g.data_access);
                    check_field("data_write", e.data_write, g.data_write);
                    check_field("data_address", e.data_address, g.data_address);
                    check_field("data_value", e.data_value, g.data_value);
                end
            end
        end
    end

endmodule

[tb/sv/sixteen_bit_risc_cpu_step_test.sv]
// Testbench top for the processor step block: program stimulus, idling and verdict
`timescale 1ns / 1ps
module sixteen_bit_risc_cpu_step_test;
    import srcs_pkg::*;

    logic             i_clk;
    logic             i_rst_n;
    logic             in_valid;
    logic             in_stall;
    t_in_item         in_data;
    logic             out_valid;
    logic             out_stall;
    t_out_item        out_data;
    logic [15:0]      cur_pc;
    logic             cur_priv;
    logic [7:0][15:0] cur_regs;
    int               pending;
    int               failures;

    logic [15:0] program_q[$];
    logic        long_hold;
    int          n_steps;
    int          n_loads;
    int          cycles;

    localparam logic [3:0] LEGAL_OPS [16] = '{OP_BR, OP_ARITH, OP_CMP, OP_JSR, OP_LOGIC,
        OP_LDR, OP_STR, OP_RTI, OP_CONST, OP_SHIFT, OP_JMP, OP_HICON, OP_TRAP,
        OP_LDR, OP_STR, OP_HICON};

    sixteen_bit_risc_cpu_step u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    sixteen_bit_risc_cpu_step_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .o_pc        (cur_pc),
        .o_priv      (cur_priv),
        .o_regs      (cur_regs),
        .o_pending   (pending),
        .o_failures  (failures)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 800000) begin
                $display("timeout after %0d cycles", cycles);
                $display("sixteen_bit_risc_cpu_step: mismatch");
                $finish;
            end
        end
    end

    function automatic logic code_ok(input logic [15:0] t, input logic p);
        return t < USER_DATA || (t >= OS_CODE && t < OS_DATA && p);
    endfunction

    function automatic logic data_ok(input logic [15:0] t);
        return (t >= USER_DATA && t < OS_CODE) || (t >= OS_DATA && cur_priv);
    endfunction

    // legal word at the current pc that neither faults nor leaves the code regions
    function automatic logic [15:0] pick_word();
        logic [15:0] ir, t;
        logic [2:0]  rs;
        logic        ok;
        if (cur_pc[12:0] == 13'h1FFF) return {OP_TRAP, 4'h0, 8'($urandom)};
        for (int tries = 0; tries < 16; tries++) begin
            ir = {LEGAL_OPS[$urandom_range(0, 15)], 12'($urandom)};
            ok = 1;
            case (ir[15:12])
                OP_BR: ok = code_ok(cur_pc + 16'd1 + {{7{ir[8]}}, ir[8:0]}, cur_priv);
                OP_JSR: begin
                    t = ir[11] ? ((cur_pc & 16'h8000) | ({{5{ir[10]}}, ir[10:0]} << 4))
                               : cur_regs[ir[8:6]];
                    ok = code_ok(t, cur_priv);
                end
                OP_JMP: begin
                    t = ir[11] ? cur_pc + 16'd1 + {{5{ir[10]}}, ir[10:0]} : cur_regs[ir[8:6]];
                    ok = code_ok(t, cur_priv);
                end
                OP_RTI: ok = code_ok(cur_regs[7], 1'b0);
                OP_LDR, OP_STR: begin
                    ok = 0;
                    rs = ir[8:6];
                    for (int k = 0; k < 8 && !ok; k++) begin
                        if (data_ok(cur_regs[rs] + {{10{ir[5]}}, ir[5:0]})) begin
                            ok = 1;
                            ir[8:6] = rs;
                        end
                        rs++;
                    end
                end
                OP_HICON: ir[8] = 1'b1;
                default: ok = 1;
            endcase
            if (ok) return ir;
        end
        return {OP_TRAP, 4'h0, 8'($urandom)};
    endfunction

    // one input beat; a code beat takes its word at drive time so the predicted state is settled
    task automatic send_beat(input t_in_item it, input logic code, input int gap);
        repeat (gap) @(negedge i_clk) in_valid <= 0;
        @(negedge i_clk);
        if (code) begin
            it.load_address = cur_pc;
            it.load_data = (program_q.size() > 0) ? program_q.pop_front() : pick_word();
        end
        in_valid <= 1;
        in_data <= it;
        do @(posedge i_clk); while (in_stall);
        if (it.kind == KIND_LOAD) n_loads++;
        else n_steps++;
    endtask

    task automatic run_one(input int gap);
        t_in_item it;
        it = {1'b0, 16'($urandom), 16'($urandom)};
        if ($urandom_range(0, 9) == 0) begin
            it.kind = KIND_LOAD;
            send_beat(it, 0, gap);
        end else begin
            it.kind = KIND_LOAD;
            send_beat(it, 1, gap);
            it = {KIND_STEP, 16'($urandom), 16'($urandom)};
            send_beat(it, 0, $urandom_range(0, 6));
        end
    endtask

    // receiver: random holds per beat, bursts with none, and one long hold
    initial begin
        int n;
        logic burst;
        out_stall = 1;
        burst = 0;
        forever begin
            if ($urandom_range(0, 19) == 0) burst = ~burst;
            n = burst ? 0 : $urandom_range(0, 6);
            if (long_hold) begin
                n = 400;
                long_hold = 0;
            end
            repeat (n) @(negedge i_clk) out_stall <= 1;
            @(negedge i_clk) out_stall <= 0;
            do @(posedge i_clk); while (!out_valid);
        end
    end

    initial begin
        int gap;
        logic burst;
        in_valid = 0;
        in_data = '0;
        long_hold = 0;
        n_steps = 0;
        n_loads = 0;
        burst = 0;
        i_rst_n = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1;

        program_q = '{16'h93FF, 16'h9405, 16'h1642, 16'h164A, 16'h1652, 16'h165A, 16'h1658,
            16'h1670, 16'h2202, 16'h2282, 16'h2340, 16'h23FF, 16'h564A, 16'h565A, 16'h567F,
            16'hD9A0, 16'h7300, 16'h6B00, 16'hAC4F, 16'hAC5F, 16'hAC6F, 16'hAC72, 16'hAC70,
            16'h0E00, 16'h0000, 16'h9E00, 16'hDF84, 16'h41C0, 16'h9E10, 16'h8000, 16'hF0FF};
        while (program_q.size() > 0) run_one(0);

        for (int i = 0; i < 520; i++) begin
            if (i == 250) long_hold = 1;
            if (i == 400) begin
                @(negedge i_clk) in_valid <= 0;
                wait (pending == 0);
            end
            if ($urandom_range(0, 29) == 0) burst = ~burst;
            gap = burst ? 0 : $urandom_range(0, 6);
            run_one(gap);
        end

        // end on an illegal opcode; afterwards steps are ignored and loads still land
        program_q.push_back({4'h3, 12'($urandom)});
        run_one(0);
        while (program_q.size() > 0 || n_steps < 520) run_one(0);
        @(negedge i_clk) in_valid <= 0;

        wait (pending == 0);
        repeat (100) @(posedge i_clk);
        $display("ran %0d loads and %0d steps over every opcode, with privilege changes,",
                 n_loads, n_steps);
        $display("output back-pressure and a final illegal-opcode halt");
        if (failures == 0) begin
            $display("sixteen_bit_risc_cpu_step: match");
        end else begin
            $display("sixteen_bit_risc_cpu_step: mismatch");
        end
        $finish;
    end

endmodule
